// ===== rtl/i2cm_pkg.sv =====
// Shared types and codes for the I2C master byte sequencer.
package i2cm_pkg;

    localparam int BYTE_W = 8;
    localparam int MODE_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WACK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_HOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd2;

    localparam logic [BYTE_W-1:0] SHORT_HOLD_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] LONG_HOLD_RST   = 8'd5;
    localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd250;

    typedef struct packed {
        logic [BYTE_W-1:0] short_hold;
        logic [BYTE_W-1:0] long_hold;
        logic [BYTE_W-1:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic              rejected;
        logic              nack_seen;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_drive;
        logic              scl_drive;
    } res_t;

endpackage

// ===== rtl/i2cm_seq.sv =====
// Phase sequencer: bus state registers and the per-beat next-state logic.
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [MODE_W-1:0] mode,
    input  logic [BYTE_W-1:0] tx_byte,
    input  logic              ack_after_read,
    input  logic              sda_sample,
    input  cfg_t              cfg,
    output res_t              res
);

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_ST_A    = 5'd1;
    localparam logic [4:0] PH_ST_B    = 5'd2;
    localparam logic [4:0] PH_ST_C    = 5'd3;
    localparam logic [4:0] PH_SP_A    = 5'd4;
    localparam logic [4:0] PH_SP_B    = 5'd5;
    localparam logic [4:0] PH_SP_C    = 5'd6;
    localparam logic [4:0] PH_WR_LOW  = 5'd7;
    localparam logic [4:0] PH_WR_DATA = 5'd8;
    localparam logic [4:0] PH_WR_HIGH = 5'd9;
    localparam logic [4:0] PH_WA_REL  = 5'd10;
    localparam logic [4:0] PH_WA_CLK  = 5'd11;
    localparam logic [4:0] PH_WA_POLL = 5'd12;
    localparam logic [4:0] PH_WA_TO_A = 5'd13;
    localparam logic [4:0] PH_WA_TO_B = 5'd14;
    localparam logic [4:0] PH_WA_TO_C = 5'd15;
    localparam logic [4:0] PH_WA_END  = 5'd16;
    localparam logic [4:0] PH_RD_HIGH = 5'd17;
    localparam logic [4:0] PH_RD_LOW  = 5'd18;
    localparam logic [4:0] PH_AK_A    = 5'd19;
    localparam logic [4:0] PH_AK_B    = 5'd20;
    localparam logic [4:0] PH_AK_C    = 5'd21;
    localparam logic [4:0] PH_AK_D    = 5'd22;

    logic [4:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] hold_reg, hold_next;
    logic [3:0]        bit_reg, bit_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [BYTE_W-1:0] poll_reg, poll_next;
    logic              pend_ack_reg, pend_ack_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic [BYTE_W-1:0] rx_reg, rx_next;
    logic              nack_reg, nack_next;

    logic       is_cmd;
    logic       do_poll;
    logic       done;
    logic       rej;
    logic [3:0] bit_inc;

    assign is_cmd  = (mode >= MODE_START) && (mode <= MODE_READ);
    assign bit_inc = bit_reg + 4'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        hold_next     = hold_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        poll_next     = poll_reg;
        pend_ack_next = pend_ack_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        rx_next       = rx_reg;
        nack_next     = nack_reg;
        done          = 1'b0;
        rej           = 1'b0;
        do_poll       = 1'b0;
        if (step)
        begin
            if (is_cmd)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    hold_next = cfg.short_hold;
                    unique case (mode)
                        MODE_START:
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_ST_A;
                        end
                        MODE_STOP:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_SP_A;
                        end
                        MODE_WRITE:
                        begin
                            shift_next = tx_byte;
                            bit_next   = 4'd0;
                            scl_next   = 1'b0;
                            phase_next = PH_WR_LOW;
                        end
                        MODE_WACK:
                        begin
                            poll_next  = '0;
                            sda_next   = 1'b1;
                            phase_next = PH_WA_REL;
                        end
                        default:
                        begin
                            pend_ack_next = ack_after_read;
                            shift_next    = '0;
                            bit_next      = 4'd0;
                            sda_next      = 1'b1;
                            scl_next      = 1'b1;
                            phase_next    = PH_RD_HIGH;
                        end
                    endcase
                end
            end
            else if (phase_reg == PH_WA_POLL)
            begin
                do_poll = 1'b1;
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (hold_reg > 8'd1)
                begin
                    hold_next = hold_reg - 8'd1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_ST_A:
                        begin
                            sda_next = 1'b0; phase_next = PH_ST_B; hold_next = cfg.long_hold;
                        end
                        PH_ST_B:
                        begin
                            scl_next = 1'b0; phase_next = PH_ST_C; hold_next = cfg.short_hold;
                        end
                        PH_SP_A:
                        begin
                            scl_next = 1'b1; phase_next = PH_SP_B; hold_next = cfg.long_hold;
                        end
                        PH_SP_B:
                        begin
                            sda_next = 1'b1; phase_next = PH_SP_C; hold_next = cfg.long_hold;
                        end
                        PH_WR_LOW:
                        begin
                            sda_next   = shift_reg[BYTE_W-1];
                            phase_next = PH_WR_DATA;
                            hold_next  = cfg.short_hold;
                        end
                        PH_WR_DATA:
                        begin
                            scl_next = 1'b1; phase_next = PH_WR_HIGH; hold_next = cfg.long_hold;
                        end
                        PH_WR_HIGH:
                        begin
                            shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                            scl_next   = 1'b0;
                            bit_next   = bit_inc;
                            if (bit_inc >= 4'd8)
                            begin
                                phase_next = PH_IDLE; hold_next = '0; done = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_WR_LOW; hold_next = cfg.short_hold;
                            end
                        end
                        PH_WA_REL:
                        begin
                            scl_next = 1'b1; phase_next = PH_WA_CLK; hold_next = cfg.short_hold;
                        end
                        PH_WA_CLK:
                        begin
                            phase_next = PH_WA_POLL;
                            do_poll    = 1'b1;
                        end
                        PH_WA_TO_A:
                        begin
                            scl_next = 1'b1; phase_next = PH_WA_TO_B; hold_next = cfg.long_hold;
                        end
                        PH_WA_TO_B:
                        begin
                            sda_next = 1'b1; phase_next = PH_WA_TO_C; hold_next = cfg.long_hold;
                        end
                        PH_WA_TO_C:
                        begin
                            scl_next = 1'b0; phase_next = PH_WA_END; hold_next = cfg.long_hold;
                        end
                        PH_RD_HIGH:
                        begin
                            shift_next = {shift_reg[BYTE_W-2:0], sda_sample};
                            scl_next   = 1'b0;
                            bit_next   = bit_inc;
                            phase_next = PH_RD_LOW;
                            hold_next  = cfg.short_hold;
                        end
                        PH_RD_LOW:
                        begin
                            hold_next = cfg.short_hold;
                            if (bit_reg >= 4'd8)
                            begin
                                rx_next    = shift_reg;
                                sda_next   = !pend_ack_reg;
                                phase_next = PH_AK_A;
                            end
                            else
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_RD_HIGH;
                            end
                        end
                        PH_AK_A:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_AK_B;
                            hold_next  = pend_ack_reg ? cfg.long_hold : cfg.short_hold;
                        end
                        PH_AK_B:
                        begin
                            scl_next = 1'b0; phase_next = PH_AK_C; hold_next = cfg.short_hold;
                        end
                        PH_AK_C:
                        begin
                            if (pend_ack_reg)
                            begin
                                sda_next = 1'b1; phase_next = PH_AK_D; hold_next = cfg.short_hold;
                            end
                            else
                            begin
                                phase_next = PH_IDLE; hold_next = '0; done = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE; hold_next = '0; done = 1'b1;
                        end
                    endcase
                end
            end
        end
        if (do_poll)
        begin
            if (!sda_sample)
            begin
                nack_next  = 1'b0;
                scl_next   = 1'b0;
                phase_next = PH_WA_END;
                hold_next  = cfg.long_hold;
            end
            else if (poll_reg >= cfg.ack_timeout)
            begin
                nack_next  = 1'b1;
                sda_next   = 1'b0;
                phase_next = PH_WA_TO_A;
                hold_next  = cfg.short_hold;
            end
            else
            begin
                poll_next = poll_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            hold_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            poll_reg     <= '0;
            pend_ack_reg <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            rx_reg       <= '0;
            nack_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hold_reg     <= hold_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            poll_reg     <= poll_next;
            pend_ack_reg <= pend_ack_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            rx_reg       <= rx_next;
            nack_reg     <= nack_next;
        end
    end

    assign res.scl_drive = scl_next;
    assign res.sda_drive = sda_next;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.done_res  = done;
    assign res.rx_byte   = rx_next;
    assign res.nack_seen = nack_next;
    assign res.rejected  = rej;

endmodule

// ===== rtl/i2c_master_byte_sequencer.sv =====
// Top level of the I2C master byte sequencer: config registers and result register.
//
// Input stream (s_axis): one beat is a tick (mode 0, 6, 7) or a command (start,
// stop, write byte, wait ack, read byte) in tuser, with tx_byte, ack_after_read
// and the sampled SDA level in tdata. Every input beat yields exactly one
// result beat on m_axis carrying the SCL/SDA drive levels, busy, done, the last
// received byte, the last ack status and a rejected flag.
// Latency: the result of a beat is valid on m_axis the cycle after it is taken.
// Throughput: one beat per clock unless a result stalls on m_axis; the sequencer
// next-state logic is combinational and a single output register holds the result.
// Stall: while a result waits with m_axis_tready low, s_axis_tready is low;
// s_axis_tready is high whenever the output register is empty or being drained.
// Config: cfg_valid/cfg_ready with cfg_index 0 short hold, 1 long hold,
// 2 ack timeout; cfg_ready is always high, other indexes are ignored.
// Reset: bus released (SCL and SDA high), sequencer idle, holds 2 and 5,
// ack timeout 250, no result pending.
module i2c_master_byte_sequencer
    import i2cm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,  // tx_byte[7:0], ack_after_read, sda_sample
    input  logic [MODE_W-1:0]    s_axis_tuser,  // mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_DATA_W-1:0]  m_axis_tdata,  // scl_drive, sda_drive, busy_res, done_res,
                                                // rx_byte[7:0], nack_seen, rejected
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    cfg_t cfg_reg;
    res_t res;
    res_t res_reg;
    logic m_valid_reg;
    logic s_beat;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_hold  <= SHORT_HOLD_RST;
            cfg_reg.long_hold   <= LONG_HOLD_RST;
            cfg_reg.ack_timeout <= ACK_TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SHORT_HOLD:  cfg_reg.short_hold  <= cfg_data;
                REG_LONG_HOLD:   cfg_reg.long_hold   <= cfg_data;
                REG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_data;
                default:         ;
            endcase
        end
    end

    i2cm_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s_beat),
        .mode           (s_axis_tuser),
        .tx_byte        (s_axis_tdata[BYTE_W-1:0]),
        .ack_after_read (s_axis_tdata[BYTE_W]),
        .sda_sample     (s_axis_tdata[BYTE_W+1]),
        .cfg            (cfg_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_beat)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - $bits(res_t)){1'b0}},
                            res_reg.rejected, res_reg.nack_seen, res_reg.rx_byte,
                            res_reg.done_res, res_reg.busy_res,
                            res_reg.sda_drive, res_reg.scl_drive};

endmodule

// ===== rtl/i2cm_chk.sv =====
// Port-level checker for the I2C master byte sequencer, bound to the top level.
module i2cm_chk
    import i2cm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done reported while still busy");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[2])
        else $error("rejected command while idle");

endmodule

bind i2c_master_byte_sequencer i2cm_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/i2cm_checker.sv =====
// Scoreboard for the I2C master sequencer: predicts each result beat and compares it.
`timescale 1ns / 1ps

module i2cm_checker
    import i2cm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    input  logic [MODE_W-1:0]    s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_DATA_W-1:0]  m_axis_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output logic                 busy_after,
    output int unsigned          pending,
    output int unsigned          errors
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_STA_REL,
        S_STA_LOW,
        S_STA_END,
        S_STO_LOW,
        S_STO_SCL,
        S_STO_END,
        S_WR_LOW,
        S_WR_DATA,
        S_WR_HIGH,
        S_WA_REL,
        S_WA_CLK,
        S_WA_POLL,
        S_TO_LOW,
        S_TO_SCL,
        S_TO_SDA,
        S_WA_END,
        S_RD_HIGH,
        S_RD_LOW,
        S_AK_DRV,
        S_AK_HIGH,
        S_AK_LOW,
        S_AK_REL
    } phase_e;

    typedef struct packed {
        phase_e            phase;
        logic [BYTE_W-1:0] hold;
        logic [3:0]        bit_cnt;
        logic [BYTE_W-1:0] shreg;
        logic [BYTE_W-1:0] polls;
        logic              ack_tail;
        logic              scl;
        logic              sda;
        logic [BYTE_W-1:0] rx;
        logic              nack;
    } bus_state_t;

    typedef struct packed {
        bus_state_t st;
        res_t       res;
    } step_t;

    function automatic step_t sequencer_step(
        input bus_state_t        cur,
        input cfg_t              c,
        input logic [MODE_W-1:0] mode,
        input logic [BYTE_W-1:0] tx,
        input logic              ackr,
        input logic              sda_in
    );
        step_t      o;
        bus_state_t st;
        logic       fin;
        logic       rej;
        logic       poll_now;
        st = cur;
        fin = 1'b0;
        rej = 1'b0;
        poll_now = 1'b0;
        if (mode >= MODE_START && mode <= MODE_READ) begin
            if (st.phase != S_IDLE) begin
                rej = 1'b1;
            end
            else begin
                st.hold = c.short_hold;
                case (mode)
                    MODE_START:
                    begin
                        st.scl = 1'b1;
                        st.sda = 1'b1;
                        st.phase = S_STA_REL;
                    end
                    MODE_STOP:
                    begin
                        st.sda = 1'b0;
                        st.phase = S_STO_LOW;
                    end
                    MODE_WRITE:
                    begin
                        st.shreg = tx;
                        st.bit_cnt = '0;
                        st.scl = 1'b0;
                        st.phase = S_WR_LOW;
                    end
                    MODE_WACK:
                    begin
                        st.polls = '0;
                        st.sda = 1'b1;
                        st.phase = S_WA_REL;
                    end
                    default:
                    begin
                        st.ack_tail = ackr;
                        st.shreg = '0;
                        st.bit_cnt = '0;
                        st.sda = 1'b1;
                        st.scl = 1'b1;
                        st.phase = S_RD_HIGH;
                    end
                endcase
            end
        end
        else if (st.phase != S_IDLE) begin
            if (st.phase == S_WA_POLL) begin
                poll_now = 1'b1;
            end
            else if (st.hold > 8'd1) begin
                st.hold = st.hold - 8'd1;
            end
            else begin
                case (st.phase)
                    S_STA_REL:
                    begin
                        st.sda = 1'b0;
                        st.phase = S_STA_LOW;
                        st.hold = c.long_hold;
                    end
                    S_STA_LOW:
                    begin
                        st.scl = 1'b0;
                        st.phase = S_STA_END;
                        st.hold = c.short_hold;
                    end
                    S_STO_LOW:
                    begin
                        st.scl = 1'b1;
                        st.phase = S_STO_SCL;
                        st.hold = c.long_hold;
                    end
                    S_STO_SCL:
                    begin
                        st.sda = 1'b1;
                        st.phase = S_STO_END;
                        st.hold = c.long_hold;
                    end
                    S_WR_LOW:
                    begin
                        st.sda = st.shreg[BYTE_W-1];
                        st.phase = S_WR_DATA;
                        st.hold = c.short_hold;
                    end
                    S_WR_DATA:
                    begin
                        st.scl = 1'b1;
                        st.phase = S_WR_HIGH;
                        st.hold = c.long_hold;
                    end
                    S_WR_HIGH:
                    begin
                        st.shreg = {st.shreg[BYTE_W-2:0], 1'b0};
                        st.scl = 1'b0;
                        st.bit_cnt = st.bit_cnt + 4'd1;
                        if (st.bit_cnt >= 4'd8) begin
                            fin = 1'b1;
                        end
                        else begin
                            st.phase = S_WR_LOW;
                            st.hold = c.short_hold;
                        end
                    end
                    S_WA_REL:
                    begin
                        st.scl = 1'b1;
                        st.phase = S_WA_CLK;
                        st.hold = c.short_hold;
                    end
                    S_WA_CLK:
                    begin
                        st.phase = S_WA_POLL;
                        poll_now = 1'b1;
                    end
                    S_TO_LOW:
                    begin
                        st.scl = 1'b1;
                        st.phase = S_TO_SCL;
                        st.hold = c.long_hold;
                    end
                    S_TO_SCL:
                    begin
                        st.sda = 1'b1;
                        st.phase = S_TO_SDA;
                        st.hold = c.long_hold;
                    end
                    S_TO_SDA:
                    begin
                        st.scl = 1'b0;
                        st.phase = S_WA_END;
                        st.hold = c.long_hold;
                    end
                    S_RD_HIGH:
                    begin
                        st.shreg = {st.shreg[BYTE_W-2:0], sda_in};
                        st.scl = 1'b0;
                        st.bit_cnt = st.bit_cnt + 4'd1;
                        st.phase = S_RD_LOW;
                        st.hold = c.short_hold;
                    end
                    S_RD_LOW:
                    begin
                        if (st.bit_cnt >= 4'd8) begin
                            st.rx = st.shreg;
                            st.sda = ~st.ack_tail;
                            st.phase = S_AK_DRV;
                        end
                        else begin
                            st.scl = 1'b1;
                            st.phase = S_RD_HIGH;
                        end
                        st.hold = c.short_hold;
                    end
                    S_AK_DRV:
                    begin
                        st.scl = 1'b1;
                        st.phase = S_AK_HIGH;
                        st.hold = st.ack_tail ? c.long_hold : c.short_hold;
                    end
                    S_AK_HIGH:
                    begin
                        st.scl = 1'b0;
                        st.phase = S_AK_LOW;
                        st.hold = c.short_hold;
                    end
                    S_AK_LOW:
                    begin
                        if (st.ack_tail) begin
                            st.sda = 1'b1;
                            st.phase = S_AK_REL;
                            st.hold = c.short_hold;
                        end
                        else begin
                            fin = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            if (poll_now) begin
                if (!sda_in) begin
                    st.nack = 1'b0;
                    st.scl = 1'b0;
                    st.phase = S_WA_END;
                    st.hold = c.long_hold;
                end
                else if (st.polls >= c.ack_timeout) begin
                    st.nack = 1'b1;
                    st.sda = 1'b0;
                    st.phase = S_TO_LOW;
                    st.hold = c.short_hold;
                end
                else begin
                    st.polls = st.polls + 8'd1;
                end
            end
            if (fin) begin
                st.phase = S_IDLE;
                st.hold = '0;
            end
        end
        o.st = st;
        o.res.scl_drive = st.scl;
        o.res.sda_drive = st.sda;
        o.res.busy_res = (st.phase != S_IDLE);
        o.res.done_res = fin;
        o.res.rx_byte = st.rx;
        o.res.nack_seen = st.nack;
        o.res.rejected = rej;
        return o;
    endfunction

    bus_state_t cur;
    cfg_t       timing;
    step_t      nxt;
    res_t       awaited_levels[$];
    res_t       want;
    res_t       got;

    always_comb
    begin
        nxt = sequencer_step(cur, timing, s_axis_tuser, s_axis_tdata[BYTE_W-1:0],
                             s_axis_tdata[BYTE_W], s_axis_tdata[BYTE_W+1]);
    end

    assign busy_after = (nxt.st.phase != S_IDLE);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur <= '{phase: S_IDLE, hold: '0, bit_cnt: '0, shreg: '0, polls: '0,
                     ack_tail: 1'b0, scl: 1'b1, sda: 1'b1, rx: '0, nack: 1'b0};
            timing <= '{short_hold: SHORT_HOLD_RST, long_hold: LONG_HOLD_RST,
                        ack_timeout: ACK_TIMEOUT_RST};
            awaited_levels.delete();
            pending <= 0;
            errors = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
                if (awaited_levels.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result beat with none pending, got %h",
                                 $time, m_axis_tdata);
                    errors++;
                end
                else begin
                    want = awaited_levels.pop_front();
                    if (got.scl_drive !== want.scl_drive || got.sda_drive !== want.sda_drive
                        || got.busy_res !== want.busy_res || got.done_res !== want.done_res
                        || got.rx_byte !== want.rx_byte || got.nack_seen !== want.nack_seen
                        || got.rejected !== want.rejected
                        || m_axis_tdata[M_DATA_W-1:$bits(res_t)] !== '0) begin
                        if (errors < 10) begin
                            $display("%0t: mismatch scl/sda/busy/done/rx/nack/rej, pad %b",
                                     $time, m_axis_tdata[M_DATA_W-1:$bits(res_t)]);
                            $display("    exp %b %b %b %b %h %b %b got %b %b %b %b %h %b %b",
                                     want.scl_drive, want.sda_drive, want.busy_res,
                                     want.done_res, want.rx_byte, want.nack_seen,
                                     want.rejected, got.scl_drive, got.sda_drive,
                                     got.busy_res, got.done_res, got.rx_byte,
                                     got.nack_seen, got.rejected);
                        end
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SHORT_HOLD:  timing.short_hold <= cfg_data;
                    REG_LONG_HOLD:   timing.long_hold <= cfg_data;
                    REG_ACK_TIMEOUT: timing.ack_timeout <= cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                cur <= nxt.st;
                awaited_levels.push_back(nxt.res);
            end
            pending <= $unsigned(awaited_levels.size());
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the I2C master sequencer testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import i2cm_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0]    MODE_SPARE_B = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int unsigned          ITEM_TARGET = 1200;
    localparam int unsigned          CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata = '0;
    logic [MODE_W-1:0]    s_axis_tuser = MODE_TICK;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SHORT_HOLD;
    logic [BYTE_W-1:0]    cfg_data = '0;

    logic                 busy_after;
    int unsigned          pending;
    int unsigned          errors;
    int unsigned          beats_sent = 0;
    int unsigned          cycles = 0;
    bit                   calm = 1'b0;

    i2c_master_byte_sequencer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    i2cm_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .busy_after    (busy_after),
        .pending       (pending),
        .errors        (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // percentage of ticks that see SDA high during an ack wait
    function automatic int unsigned pick_high_pct();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 20;
        if (r < 85)
            return 80;
        return 100;
    endfunction

    initial
    begin
        int unsigned stall;
        forever
        begin
            stall = pick_gap();
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] tx,
                             input logic ackr, input logic sda);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {{(S_DATA_W-BYTE_W-2){1'b0}}, sda, ackr, tx};
        do @(posedge clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    task automatic tick(input logic sda);
        logic [MODE_W-1:0] mode;
        mode = MODE_TICK;
        if ($urandom_range(0, 9) == 0)
            mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        send_beat(mode, 8'($urandom), 1'($urandom), sda);
    endtask

    // issue one command, then tick until the sequence completes; noise_pct of the
    // ticks are replaced by commands that must be refused
    task automatic run_command(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] tx,
                               input logic ackr, input int unsigned high_pct,
                               input int unsigned noise_pct);
        send_beat(mode, tx, ackr, 1'($urandom));
        while (busy_after)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_beat(3'($urandom_range(MODE_START, MODE_READ)), 8'($urandom),
                          1'($urandom), 1'($urandom));
            else
                tick($urandom_range(0, 99) < high_pct);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [BYTE_W-1:0] sh, input logic [BYTE_W-1:0] lh,
                              input logic [BYTE_W-1:0] tmo);
        wait_drain();
        cfg_write(REG_SHORT_HOLD, sh);
        cfg_write(REG_LONG_HOLD, lh);
        cfg_write(REG_ACK_TIMEOUT, tmo);
    endtask

    task automatic run_transfer();
        int unsigned n;
        run_command(MODE_START, 8'($urandom), 1'($urandom), 50, 3);
        run_command(MODE_WRITE, 8'($urandom), 1'($urandom), 50, 3);
        run_command(MODE_WACK, 8'($urandom), 1'($urandom), pick_high_pct(), 3);
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 1)) begin
                run_command(MODE_WRITE, 8'($urandom), 1'($urandom), 50, 3);
                run_command(MODE_WACK, 8'($urandom), 1'($urandom), pick_high_pct(), 3);
            end
            else begin
                run_command(MODE_READ, 8'($urandom), 1'($urandom), 50, 3);
            end
        end
        run_command(MODE_STOP, 8'($urandom), 1'($urandom), 50, 3);
    endtask

    initial
    begin
        int unsigned r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle ticks and a start on reset timing
        tick(1'b0);
        send_beat(MODE_SPARE_A, 8'hFF, 1'b1, 1'b1);
        send_beat(MODE_SPARE_B, 8'h00, 1'b0, 1'b0);
        run_command(MODE_START, 8'h00, 1'b0, 50, 0);

        set_timing(8'd1, 8'd1, 8'd2);
        run_command(MODE_WRITE, 8'hFF, 1'b0, 50, 0);
        run_command(MODE_WACK, 8'h00, 1'b0, 0, 0);
        run_command(MODE_WRITE, 8'h00, 1'b1, 50, 0);
        run_command(MODE_WACK, 8'h00, 1'b0, 100, 0);
        run_command(MODE_READ, 8'h00, 1'b1, 100, 0);
        run_command(MODE_READ, 8'hFF, 1'b0, 0, 0);
        run_command(MODE_STOP, 8'h00, 1'b0, 50, 30);
        wait_drain();
        cfg_write(REG_NONE, 8'($urandom));

        // zero holds and zero timeout
        set_timing(8'd0, 8'd0, 8'd0);
        run_command(MODE_START, 8'h00, 1'b0, 50, 0);
        run_command(MODE_WACK, 8'h00, 1'b0, 100, 0);
        run_command(MODE_READ, 8'h00, 1'b1, 50, 0);
        run_command(MODE_STOP, 8'h00, 1'b0, 50, 0);

        // register extremes
        set_timing(8'd255, 8'd1, 8'd1);
        run_command(MODE_STOP, 8'h00, 1'b0, 50, 2);
        set_timing(8'd1, 8'd255, 8'd255);
        run_command(MODE_START, 8'h00, 1'b0, 50, 2);
        set_timing(8'd1, 8'd1, 8'd255);
        run_command(MODE_WACK, 8'h00, 1'b0, 100, 2);

        while (beats_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                set_timing(8'($urandom_range(1, 3)), 8'($urandom_range(1, 4)),
                           8'($urandom_range(0, 6)));
            else if (r < 90)
                set_timing(8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                           8'($urandom_range(0, 1)));
            else
                set_timing(8'($urandom_range(4, 10)), 8'($urandom_range(4, 10)),
                           8'($urandom_range(10, 40)));
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 99) < 75)
                    run_transfer();
                else
                    run_command(3'($urandom_range(MODE_START, MODE_READ)), 8'($urandom),
                                1'($urandom), pick_high_pct(), 10);
                repeat ($urandom_range(0, 2)) tick(1'($urandom));
            end
        end

        calm = 1'b0;
        wait_drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
